// ----- hw/rtl/plwb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plwb_pkg;

    localparam int unsigned Q_W       = 32;
    localparam int unsigned TS_W      = 17;
    localparam int unsigned BOUND_W   = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WIDE_W    = 66;

    // divider: 49-bit dividend, 32-bit divisor, 32-bit quotient with an overflow flag
    localparam int unsigned DIV_N_W   = 49;
    localparam int unsigned DIV_D_W   = 32;
    localparam int unsigned DIV_Q_W   = 32;
    localparam int unsigned DIV_STEP  = 4;

    // x / 10 as multiply by reciprocal, exact for 32-bit x
    localparam logic [31:0] TENTH_MULT  = 32'hCCCCCCCD;
    localparam int unsigned TENTH_SHIFT = 35;
    localparam int unsigned TENTH_W     = 28;

    localparam logic [TS_W-1:0]    RST_TIME_STEP  = 17'd164;
    localparam logic               RST_START_MODE = 1'b1;
    localparam logic [BOUND_W-1:0] RST_BOUND_X    = 31'd131072;
    localparam logic [BOUND_W-1:0] RST_BOUND_Y    = 31'd131072;
    localparam logic [BOUND_W-1:0] RST_BOUND_Z    = 31'd196608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_START_MODE = 3'd1,
        CFG_BOUND_X    = 3'd2,
        CFG_BOUND_Y    = 3'd3,
        CFG_BOUND_Z    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][Q_W-1:0] p;
        logic [2:0][Q_W-1:0] v;
        logic [2:0][Q_W-1:0] h;
    } t_part;

    typedef struct packed {
        t_part part;
        logic  hit;
        logic  neg;
        logic  vzero;
    } t_wall_side;

    function automatic logic signed [WIDE_W-1:0] sx(input logic [Q_W-1:0] x);
        return WIDE_W'($signed(x));
    endfunction

    function automatic logic [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic [Q_W-1:0] r;
        if (x > $signed(66'sh7FFFFFFF)) begin
            r = 32'h7FFFFFFF;
        end else if (x < -$signed(66'sh80000000)) begin
            r = 32'h80000000;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

    // round half up: floor((x + 2^(s-1)) / 2^s)
    function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] x,
                                                     input int unsigned s);
        logic signed [WIDE_W-1:0] y;
        y = x + ($signed(66'sd1) <<< (s - 1));
        return y >>> s;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/plwb_integrate.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plwb_integrate (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire plwb_pkg::t_part                 i_part,
    input  wire logic [2:0][plwb_pkg::Q_W-1:0]   i_acc,
    input  wire logic [plwb_pkg::TS_W-1:0]       i_time_step,
    input  wire logic                            i_start_mode,
    output logic                                 o_valid,
    output plwb_pkg::t_part                      o_part
);

    logic              r0_vld, r1_vld, r2_vld, r3_vld;
    plwb_pkg::t_part   r0_part, r1_part, r2_part, r3_part;
    logic signed [49:0] r0_ad [0:2];
    logic signed [33:0] r1_r17 [0:2];
    logic              r1_start;
    logic signed [49:0] r2_hd [0:2];

    plwb_pkg::t_part   n1_part, n2_part, n3_part;
    logic signed [33:0] n1_r17 [0:2];
    logic signed [49:0] n2_hd [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_comb begin
        n1_part = r0_part;
        for (int c = 0; c < 3; c++) begin
            n1_r17[c] = 34'(plwb_pkg::rnd(66'(r0_ad[c]), 17));
            if (i_start_mode) begin
                n1_part.h[c] = plwb_pkg::sat32(plwb_pkg::sx(r0_part.v[c])
                                               + plwb_pkg::rnd(66'(r0_ad[c]), 17));
                n1_part.v[c] = plwb_pkg::sat32(plwb_pkg::sx(r0_part.v[c])
                                               + plwb_pkg::rnd(66'(r0_ad[c]), 16));
            end else begin
                n1_part.h[c] = plwb_pkg::sat32(plwb_pkg::sx(r0_part.h[c])
                                               + plwb_pkg::rnd(66'(r0_ad[c]), 16));
            end
        end
    end

    always_comb begin
        n2_part = r1_part;
        for (int c = 0; c < 3; c++) begin
            if (!r1_start) begin
                n2_part.v[c] = plwb_pkg::sat32(plwb_pkg::sx(r1_part.h[c])
                                               + 66'(r1_r17[c]));
            end
            n2_hd[c] = $signed(r1_part.h[c]) * $signed({1'b0, i_time_step});
        end
    end

    always_comb begin
        n3_part = r2_part;
        for (int c = 0; c < 3; c++) begin
            n3_part.p[c] = plwb_pkg::sat32(plwb_pkg::sx(r2_part.p[c])
                                           + plwb_pkg::rnd(66'(r2_hd[c]), 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_part  <= i_part;
            for (int c = 0; c < 3; c++) begin
                r0_ad[c]  <= $signed(i_acc[c]) * $signed({1'b0, i_time_step});
                r1_r17[c] <= n1_r17[c];
                r2_hd[c]  <= n2_hd[c];
            end
            r1_part  <= n1_part;
            r1_start <= i_start_mode;
            r2_part  <= n2_part;
            r3_part  <= n3_part;
        end
    end

    assign o_valid = r3_vld;
    assign o_part  = r3_part;

endmodule

`default_nettype wire

// ----- hw/rtl/plwb_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plwb_div #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [plwb_pkg::DIV_N_W-1:0]  i_num,
    input  wire logic [plwb_pkg::DIV_D_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0]             i_side,
    output logic                               o_valid,
    output logic [plwb_pkg::DIV_Q_W-1:0]       o_quot,
    output logic                               o_ovf,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int unsigned NSTG = plwb_pkg::DIV_Q_W / plwb_pkg::DIV_STEP;

    logic                              r_vld  [0:NSTG];
    logic [plwb_pkg::DIV_D_W:0]        r_rem  [0:NSTG];
    logic [plwb_pkg::DIV_Q_W-1:0]      r_low  [0:NSTG];
    logic [plwb_pkg::DIV_Q_W-1:0]      r_q    [0:NSTG];
    logic [plwb_pkg::DIV_D_W-1:0]      r_den  [0:NSTG];
    logic                              r_ovf  [0:NSTG];
    logic [SIDE_W-1:0]                 r_side [0:NSTG];

    // quotient fits 32 bits unless the top dividend bits already reach the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {16'd0, i_num[48:32]};
            r_low[0]  <= i_num[31:0];
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= ({15'd0, i_num[48:32]} >= i_den);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= NSTG; k++) begin : g_stg
        logic [plwb_pkg::DIV_D_W:0]   n_rem;
        logic [plwb_pkg::DIV_Q_W-1:0] n_low;
        logic [plwb_pkg::DIV_Q_W-1:0] n_q;

        always_comb begin
            n_rem = r_rem[k-1];
            n_low = r_low[k-1];
            n_q   = r_q[k-1];
            for (int b = 0; b < plwb_pkg::DIV_STEP; b++) begin
                n_rem = {n_rem[31:0], n_low[31]};
                n_low = {n_low[30:0], 1'b0};
                if (n_rem >= {1'b0, r_den[k-1]}) begin
                    n_rem = n_rem - {1'b0, r_den[k-1]};
                    n_q   = {n_q[30:0], 1'b1};
                end else begin
                    n_q   = {n_q[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_q[k]    <= n_q;
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[NSTG];
    assign o_quot  = r_q[NSTG];
    assign o_ovf   = r_ovf[NSTG];
    assign o_side  = r_side[NSTG];

endmodule

`default_nettype wire

// ----- hw/rtl/plwb_wall.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plwb_wall #(
    parameter int unsigned AXIS   = 0,
    parameter bit          IS_LOW = 1'b1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire plwb_pkg::t_part           i_part,
    input  wire logic [plwb_pkg::Q_W-1:0]  i_level,
    output logic                           o_valid,
    output plwb_pkg::t_part                o_part
);

    localparam int unsigned SIDE_W = $bits(plwb_pkg::t_wall_side);

    // entry stage: hit test and overshoot magnitude
    logic                 r0_vld;
    plwb_pkg::t_wall_side r0_side;
    logic [32:0]          r0_oabs;
    logic [31:0]          r0_vabs;

    logic signed [33:0]   n0_o;
    logic                 n0_hit;
    plwb_pkg::t_wall_side n0_side;

    always_comb begin
        n0_o   = 34'($signed(i_part.p[AXIS])) - 34'($signed(i_level));
        n0_hit = IS_LOW ? ($signed(i_part.p[AXIS]) <= $signed(i_level))
                        : ($signed(i_part.p[AXIS]) >= $signed(i_level));
        n0_side.part  = i_part;
        n0_side.hit   = n0_hit;
        n0_side.neg   = n0_o[33] ^ i_part.v[AXIS][31];
        n0_side.vzero = (i_part.v[AXIS] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_side <= n0_side;
            r0_oabs <= n0_o[33] ? 33'(-n0_o) : n0_o[32:0];
            r0_vabs <= i_part.v[AXIS][31] ? (~i_part.v[AXIS] + 32'd1) : i_part.v[AXIS];
        end
    end

    logic                 d_vld;
    logic [31:0]          d_quot;
    logic                 d_ovf;
    logic [SIDE_W-1:0]    d_side_bits;
    plwb_pkg::t_wall_side d_side;

    plwb_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r0_vld),
        .i_num   ({r0_oabs[32:0], 16'd0}),
        .i_den   (r0_vabs),
        .i_side  (r0_side),
        .o_valid (d_vld),
        .o_quot  (d_quot),
        .o_ovf   (d_ovf),
        .o_side  (d_side_bits)
    );

    assign d_side = plwb_pkg::t_wall_side'(d_side_bits);

    // signed, saturated overshoot time
    logic              rt_vld;
    plwb_pkg::t_part   rt_part;
    logic              rt_hit;
    logic [31:0]       rt_t;
    logic [31:0]       n_t;

    always_comb begin
        if (d_side.vzero) begin
            n_t = '0;
        end else if (d_ovf) begin
            n_t = d_side.neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else if (d_side.neg) begin
            n_t = (d_quot > 32'h80000000) ? 32'h80000000 : (~d_quot + 32'd1);
        end else begin
            n_t = (d_quot > 32'h7FFFFFFF) ? 32'h7FFFFFFF : d_quot;
        end
    end

    // back-off products
    logic               rm_vld;
    plwb_pkg::t_part    rm_part;
    logic               rm_hit;
    logic signed [63:0] rm_prod [0:2];

    // back-off and normal flip
    logic               rb_vld;
    plwb_pkg::t_part    rb_part;
    logic               rb_hit;
    plwb_pkg::t_part    n_b;

    always_comb begin
        n_b = rm_part;
        if (rm_hit) begin
            for (int c = 0; c < 3; c++) begin
                n_b.p[c] = plwb_pkg::sat32(plwb_pkg::sx(rm_part.p[c])
                                           - plwb_pkg::rnd(66'(rm_prod[c]), 18));
            end
            n_b.v[AXIS] = plwb_pkg::sat32(-plwb_pkg::sx(rm_part.v[AXIS]));
            n_b.h[AXIS] = plwb_pkg::sat32(-plwb_pkg::sx(rm_part.h[AXIS]));
        end
    end

    // reflection and damping by 0.75
    logic               rr_vld;
    plwb_pkg::t_part    rr_part;
    plwb_pkg::t_part    n_r;

    always_comb begin
        n_r = rb_part;
        if (rb_hit) begin
            n_r.p[AXIS] = plwb_pkg::sat32($signed(66'sd2) * plwb_pkg::sx(i_level)
                                          - plwb_pkg::sx(rb_part.p[AXIS]));
            for (int c = 0; c < 3; c++) begin
                n_r.v[c] = plwb_pkg::sat32(plwb_pkg::rnd($signed(66'sd3)
                                           * plwb_pkg::sx(rb_part.v[c]), 2));
                n_r.h[c] = plwb_pkg::sat32(plwb_pkg::rnd($signed(66'sd3)
                                           * plwb_pkg::sx(rb_part.h[c]), 2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            rt_vld <= 1'b0;
            rm_vld <= 1'b0;
            rb_vld <= 1'b0;
            rr_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
            rt_vld <= d_vld;
            rm_vld <= rt_vld;
            rb_vld <= rm_vld;
            rr_vld <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rt_part <= d_side.part;
            rt_hit  <= d_side.hit;
            rt_t    <= n_t;
            rm_part <= rt_part;
            rm_hit  <= rt_hit;
            for (int c = 0; c < 3; c++) begin
                rm_prod[c] <= $signed(rt_part.v[c]) * $signed(rt_t);
            end
            rb_part <= n_b;
            rb_hit  <= rm_hit;
            rr_part <= n_r;
        end
    end

    assign o_valid = rr_vld;
    assign o_part  = rr_part;

endmodule

`default_nettype wire

// ----- hw/rtl/particle_leapfrog_wall_bounce_core.sv -----
// pipeline: 4 integration stages, then 14 per wall for six walls; each wall
// holds a 9-stage divider for the overshoot time, 4 quotient bits per stage
// throughput: one transaction per cycle; an output stall holds the whole pipe
// reset: clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module particle_leapfrog_wall_bounce_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [plwb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [plwb_pkg::BOUND_W-1:0]        i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [31:0]                         i_pos_x,
    input  wire logic [31:0]                         i_pos_y,
    input  wire logic [31:0]                         i_pos_z,
    input  wire logic [31:0]                         i_vel_x,
    input  wire logic [31:0]                         i_vel_y,
    input  wire logic [31:0]                         i_vel_z,
    input  wire logic [31:0]                         i_half_vel_x,
    input  wire logic [31:0]                         i_half_vel_y,
    input  wire logic [31:0]                         i_half_vel_z,
    input  wire logic [31:0]                         i_acc_x,
    input  wire logic [31:0]                         i_acc_y,
    input  wire logic [31:0]                         i_acc_z,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [31:0]                              o_new_pos_x,
    output logic [31:0]                              o_new_pos_y,
    output logic [31:0]                              o_new_pos_z,
    output logic [31:0]                              o_new_vel_x,
    output logic [31:0]                              o_new_vel_y,
    output logic [31:0]                              o_new_vel_z,
    output logic [31:0]                              o_new_half_vel_x,
    output logic [31:0]                              o_new_half_vel_y,
    output logic [31:0]                              o_new_half_vel_z
);

    logic [plwb_pkg::TS_W-1:0]    r_time_step;
    logic                         r_start_mode;
    logic [plwb_pkg::BOUND_W-1:0] r_bound_x;
    logic [plwb_pkg::BOUND_W-1:0] r_bound_y;
    logic [plwb_pkg::BOUND_W-1:0] r_bound_z;
    logic [plwb_pkg::TENTH_W-1:0] r_bx_tenth;
    logic [62:0]                  n_bx_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= plwb_pkg::RST_TIME_STEP;
            r_start_mode <= plwb_pkg::RST_START_MODE;
            r_bound_x    <= plwb_pkg::RST_BOUND_X;
            r_bound_y    <= plwb_pkg::RST_BOUND_Y;
            r_bound_z    <= plwb_pkg::RST_BOUND_Z;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                plwb_pkg::CFG_TIME_STEP:  r_time_step  <= i_cfg_data[plwb_pkg::TS_W-1:0];
                plwb_pkg::CFG_START_MODE: r_start_mode <= i_cfg_data[0];
                plwb_pkg::CFG_BOUND_X:    r_bound_x    <= i_cfg_data;
                plwb_pkg::CFG_BOUND_Y:    r_bound_y    <= i_cfg_data;
                plwb_pkg::CFG_BOUND_Z:    r_bound_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // low x wall sits at minus a tenth of the bound
    assign n_bx_prod = 63'(r_bound_x) * 63'(plwb_pkg::TENTH_MULT);

    always_ff @(posedge i_clk) begin
        r_bx_tenth <= plwb_pkg::TENTH_W'(n_bx_prod >> plwb_pkg::TENTH_SHIFT);
    end

    logic [31:0] lvl [0:5];

    assign lvl[0] = 32'(-$signed({1'b0, r_bound_y}));
    assign lvl[1] = {1'b0, r_bound_y};
    assign lvl[2] = 32'(-$signed({4'd0, r_bx_tenth}));
    assign lvl[3] = {1'b0, r_bound_x};
    assign lvl[4] = 32'(-$signed({1'b0, r_bound_z}));
    assign lvl[5] = {1'b0, r_bound_z};

    logic                 adv;
    plwb_pkg::t_part      in_part;
    logic [2:0][31:0]     in_acc;
    logic                 vld_c  [0:6];
    plwb_pkg::t_part      part_c [0:6];

    assign adv     = !vld_c[6] || i_ready;
    assign o_ready = adv;

    assign in_part.p = {i_pos_z, i_pos_y, i_pos_x};
    assign in_part.v = {i_vel_z, i_vel_y, i_vel_x};
    assign in_part.h = {i_half_vel_z, i_half_vel_y, i_half_vel_x};
    assign in_acc    = {i_acc_z, i_acc_y, i_acc_x};

    plwb_integrate u_integrate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_valid      (i_valid),
        .i_part       (in_part),
        .i_acc        (in_acc),
        .i_time_step  (r_time_step),
        .i_start_mode (r_start_mode),
        .o_valid      (vld_c[0]),
        .o_part       (part_c[0])
    );

    // wall order: low y, high y, low x, high x, low z, high z
    for (genvar w = 0; w < 6; w++) begin : g_wall
        plwb_wall #(
            .AXIS   ((w < 2) ? 1 : ((w < 4) ? 0 : 2)),
            .IS_LOW ((w % 2) == 0)
        ) u_wall (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (vld_c[w]),
            .i_part  (part_c[w]),
            .i_level (lvl[w]),
            .o_valid (vld_c[w+1]),
            .o_part  (part_c[w+1])
        );
    end

    assign o_valid          = vld_c[6];
    assign o_new_pos_x      = part_c[6].p[0];
    assign o_new_pos_y      = part_c[6].p[1];
    assign o_new_pos_z      = part_c[6].p[2];
    assign o_new_vel_x      = part_c[6].v[0];
    assign o_new_vel_y      = part_c[6].v[1];
    assign o_new_vel_z      = part_c[6].v[2];
    assign o_new_half_vel_x = part_c[6].h[0];
    assign o_new_half_vel_y = part_c[6].h[1];
    assign o_new_half_vel_z = part_c[6].h[2];

endmodule

`default_nettype wire

// ----- verif/tb_particle_leapfrog_wall_bounce_core.sv -----
`timescale 1ns / 1ps

module tb_particle_leapfrog_wall_bounce_core;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 100;
    localparam int          RAND_PER_PHASE = 160;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          N_ROWS         = 8;
    localparam logic [plwb_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam logic [31:0] Q_POS_MAX      = 32'h7FFFFFFF;
    localparam logic [31:0] Q_NEG_MAX      = 32'h80000000;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        logic [2:0][31:0] h;
        logic [2:0][31:0] a;
    } t_particle;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        logic [2:0][31:0] h;
    } t_motion;

    typedef struct {
        t_particle pt;
        bit        known;
        t_motion   res;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [plwb_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [plwb_pkg::BOUND_W-1:0]   i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic [31:0]          i_pos_x, i_pos_y, i_pos_z;
    logic [31:0]          i_vel_x, i_vel_y, i_vel_z;
    logic [31:0]          i_half_vel_x, i_half_vel_y, i_half_vel_z;
    logic [31:0]          i_acc_x, i_acc_y, i_acc_z;
    logic                 o_valid;
    logic                 i_ready;
    logic [31:0]          o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic [31:0]          o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic [31:0]          o_new_half_vel_x, o_new_half_vel_y, o_new_half_vel_z;

    particle_leapfrog_wall_bounce_core i_dut (.*);

    // shadow copy of the register file
    logic [plwb_pkg::TS_W-1:0]    step_reg;
    logic                         start_reg;
    logic [plwb_pkg::BOUND_W-1:0] bx_reg, by_reg, bz_reg;

    longint  wp[3], wv[3], wh[3];
    t_motion pending_updates[$];
    int      mismatch_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_req;
    int      hold_left;
    int      idle_cycles;
    t_row    rows[N_ROWS];

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint round_sh(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic void reflect_wall(int n, longint lvl, bit low);
        longint o;
        longint t;
        bit     hit;
        hit = low ? (wp[n] <= lvl) : (wp[n] >= lvl);
        if (!hit) return;
        o = wp[n] - lvl;
        t = (wv[n] == 0) ? 0 : clamp32((o * 65536) / wv[n]);
        for (int c = 0; c < 3; c++) wp[c] = clamp32(wp[c] - round_sh(wv[c] * t, 18));
        wp[n] = clamp32(2 * lvl - wp[n]);
        wv[n] = clamp32(-wv[n]);
        wh[n] = clamp32(-wh[n]);
        for (int c = 0; c < 3; c++) begin
            wv[c] = clamp32(round_sh(3 * wv[c], 2));
            wh[c] = clamp32(round_sh(3 * wh[c], 2));
        end
    endfunction

    function automatic t_motion integrate_and_bounce(t_particle pt);
        longint  d;
        longint  ad;
        t_motion r;
        d = longint'(step_reg);
        for (int c = 0; c < 3; c++) begin
            wp[c] = longint'($signed(pt.p[c]));
            wv[c] = longint'($signed(pt.v[c]));
            wh[c] = longint'($signed(pt.h[c]));
            ad = longint'($signed(pt.a[c])) * d;
            if (start_reg) begin
                wh[c] = clamp32(wv[c] + round_sh(ad, 17));
                wv[c] = clamp32(wv[c] + round_sh(ad, 16));
            end else begin
                wh[c] = clamp32(wh[c] + round_sh(ad, 16));
                wv[c] = clamp32(wh[c] + round_sh(ad, 17));
            end
            wp[c] = clamp32(wp[c] + round_sh(wh[c] * d, 16));
        end
        reflect_wall(1, -longint'(by_reg), 1'b1);
        reflect_wall(1, longint'(by_reg), 1'b0);
        reflect_wall(0, -(longint'(bx_reg) / 10), 1'b1);
        reflect_wall(0, longint'(bx_reg), 1'b0);
        reflect_wall(2, -longint'(bz_reg), 1'b1);
        reflect_wall(2, longint'(bz_reg), 1'b0);
        for (int c = 0; c < 3; c++) begin
            r.p[c] = wp[c][31:0];
            r.v[c] = wv[c][31:0];
            r.h[c] = wh[c][31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] near(int unsigned s);
        longint r;
        r = longint'($urandom_range(2 * s)) - longint'(s);
        return r[31:0];
    endfunction

    function automatic logic [31:0] corner_value();
        case ($urandom_range(4))
            0: return Q_POS_MAX;
            1: return Q_NEG_MAX;
            2: return 32'd0;
            3: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_particle make_particle();
        t_particle   pt;
        int unsigned kind;
        int unsigned ps, vs, as;
        kind = $urandom_range(99);
        ps = 1 << $urandom_range(14, 22);
        vs = 1 << $urandom_range(10, 24);
        as = 1 << $urandom_range(8, 26);
        for (int c = 0; c < 3; c++) begin
            if (kind < 60) begin
                pt.p[c] = near(ps);
                pt.v[c] = near(vs);
                pt.h[c] = near(vs);
                pt.a[c] = near(as);
            end else if (kind < 85) begin
                pt.p[c] = $urandom;
                pt.v[c] = $urandom;
                pt.h[c] = $urandom;
                pt.a[c] = $urandom;
            end else begin
                pt.p[c] = corner_value();
                pt.v[c] = corner_value();
                pt.h[c] = corner_value();
                pt.a[c] = corner_value();
            end
        end
        return pt;
    endfunction

    function automatic void apply_reg(logic [plwb_pkg::CFG_IDX_W-1:0] idx,
                                      logic [plwb_pkg::BOUND_W-1:0] val);
        case (idx)
            plwb_pkg::CFG_TIME_STEP:  step_reg  = val[plwb_pkg::TS_W-1:0];
            plwb_pkg::CFG_START_MODE: start_reg = val[0];
            plwb_pkg::CFG_BOUND_X:    bx_reg    = val;
            plwb_pkg::CFG_BOUND_Y:    by_reg    = val;
            plwb_pkg::CFG_BOUND_Z:    bz_reg    = val;
            default: ;
        endcase
    endfunction

    // write enable stays high across the burst and drops once at the end
    task automatic load_config(logic [plwb_pkg::BOUND_W-1:0] ts, logic sm,
                               logic [plwb_pkg::BOUND_W-1:0] bx,
                               logic [plwb_pkg::BOUND_W-1:0] by,
                               logic [plwb_pkg::BOUND_W-1:0] bz);
        logic [plwb_pkg::CFG_IDX_W-1:0] idx[6];
        logic [plwb_pkg::BOUND_W-1:0]   val[6];
        idx = '{CFG_UNUSED_IDX, plwb_pkg::CFG_TIME_STEP, plwb_pkg::CFG_START_MODE,
                plwb_pkg::CFG_BOUND_X, plwb_pkg::CFG_BOUND_Y, plwb_pkg::CFG_BOUND_Z};
        val = '{31'($urandom), ts, {30'($urandom), sm}, bx, by, bz};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            apply_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_particle(t_particle pt, t_motion typed, bit use_typed);
        t_motion exp_m;
        // sender idles at random with valid low before the transaction
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pos_x      <= pt.p[0];
        i_pos_y      <= pt.p[1];
        i_pos_z      <= pt.p[2];
        i_vel_x      <= pt.v[0];
        i_vel_y      <= pt.v[1];
        i_vel_z      <= pt.v[2];
        i_half_vel_x <= pt.h[0];
        i_half_vel_y <= pt.h[1];
        i_half_vel_z <= pt.h[2];
        i_acc_x      <= pt.a[0];
        i_acc_y      <= pt.a[1];
        i_acc_z      <= pt.a[2];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_m = use_typed ? typed : integrate_and_bounce(pt);
        pending_updates = {pending_updates, exp_m};
    endtask

    // sender pauses until the pipe has emptied
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_motion exp_m, got;
        string   fname[3];
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got.p = {o_new_pos_z, o_new_pos_y, o_new_pos_x};
                got.v = {o_new_vel_z, o_new_vel_y, o_new_vel_x};
                got.h = {o_new_half_vel_z, o_new_half_vel_y, o_new_half_vel_x};
                if (pending_updates.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result transaction");
                end else begin
                    exp_m = pending_updates.pop_front();
                    fname = '{"x", "y", "z"};
                    for (int c = 0; c < 3; c++) begin
                        if (got.p[c] !== exp_m.p[c] || got.v[c] !== exp_m.v[c] ||
                            got.h[c] !== exp_m.h[c]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("axis %s: pos %h/%h vel %h/%h half %h/%h (exp/got)",
                                         fname[c], exp_m.p[c], got.p[c], exp_m.v[c],
                                         got.v[c], exp_m.h[c], got.h[c]);
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left <= HOLD_CYCLES;
                i_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("particle_leapfrog_wall_bounce_core regression: fail");
            $finish;
        end
    end

    initial begin
        t_motion   zero_m;
        t_motion   wall_m;
        t_particle pt;
        zero_m = '0;
        wall_m = '0;
        wall_m.p[1] = -32'sd131072;

        rows[0] = '{'0, 1'b1, zero_m};
        pt = '0;
        pt.p[1] = -32'sd131072;
        rows[1] = '{pt, 1'b1, wall_m};
        rows[2] = '{{12{Q_POS_MAX}}, 1'b0, zero_m};
        rows[3] = '{{12{Q_NEG_MAX}}, 1'b0, zero_m};
        rows[4] = '{{{3{Q_NEG_MAX}}, {3{Q_POS_MAX}}, {3{Q_NEG_MAX}}, {3{Q_POS_MAX}}},
                    1'b0, zero_m};
        // moving fast into the high y wall
        pt = '0;
        pt.p[1] = 32'sd120000;
        pt.v[1] = 32'sd500000;
        pt.h[1] = 32'sd500000;
        rows[5] = '{pt, 1'b0, zero_m};
        // crossing the low x wall at minus a tenth of the bound
        pt = '0;
        pt.p[0] = -32'sd20000;
        pt.v[0] = -32'sd300000;
        pt.a[0] = -32'sd65536;
        rows[6] = '{pt, 1'b0, zero_m};
        // several walls in one step
        pt = '0;
        pt.p = {32'sd200000, -32'sd140000, 32'sd140000};
        pt.v = {32'sd1048576, -32'sd70000, 32'sd9000};
        pt.h = {-32'sd5000, 32'sd70000, 32'sd1};
        pt.a = {Q_POS_MAX, Q_NEG_MAX, 32'sd3};
        rows[7] = '{pt, 1'b0, zero_m};

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        {i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z} = '0;
        {i_half_vel_x, i_half_vel_y, i_half_vel_z, i_acc_x, i_acc_y, i_acc_z} = '0;
        step_reg       = plwb_pkg::RST_TIME_STEP;
        start_reg      = plwb_pkg::RST_START_MODE;
        bx_reg         = plwb_pkg::RST_BOUND_X;
        by_reg         = plwb_pkg::RST_BOUND_Y;
        bz_reg         = plwb_pkg::RST_BOUND_Z;
        mismatch_count = 0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        send_idle_pct  = 26;
        recv_stall_pct = 70;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, then the two extreme register corners
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) load_config(31'd65536, 1'b0, '0, '0, '0);
            if (pass == 2) load_config('0, 1'b1, '1, '1, '1);
            for (int r = 0; r < N_ROWS; r++)
                offer_particle(rows[r].pt, rows[r].res, rows[r].known && pass == 0);
            drain();
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: load_config(31'($urandom_range(65536)), 1'b0,
                               31'($urandom_range(1 << 20, 1 << 16)),
                               31'($urandom_range(1 << 20, 1 << 16)),
                               31'($urandom_range(1 << 20, 1 << 16)));
                1: load_config(31'd65536, 1'b1, 31'($urandom_range(1 << 22)),
                               31'($urandom_range(1 << 22)), 31'($urandom_range(1 << 22)));
                default: load_config(31'($urandom_range(65536)), 1'b0, '1, '0,
                                     31'($urandom));
            endcase
            send_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 70 : 0;
            recv_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 26 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // long receiver hold while items keep coming
                if (ph == 2 && n == 20) hold_req = 1'b1;
                offer_particle(make_particle(), zero_m, 1'b0);
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("particle_leapfrog_wall_bounce_core regression: pass");
        end else begin
            $display("particle_leapfrog_wall_bounce_core regression: fail");
        end
        $finish;
    end

endmodule
